// File: hdl/rcst_pkg.sv
// Shared types and constants of the range clamp segment tree.
`default_nettype none
package rcst_pkg;

    localparam int REQ_W  = 2;
    localparam int POS_W  = 10;
    localparam int HIN_W  = 17;
    localparam int HOUT_W = 17;

    typedef enum logic [1:0] {
        REQ_RAISE = 2'd0,
        REQ_LOWER = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        RS_U,
        RS_L,
        RS_R
    } t_rsel;

    typedef enum logic [2:0] {
        WS_NONE,
        WS_CLEAR,
        WS_COVER,
        WS_LEFT,
        WS_RIGHT,
        WS_IDENT
    } t_wsel;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_CHL,
        S_CHR,
        S_PAR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic  start;
        t_rsel rsel;
        t_wsel wsel;
        logic  latch_par;
        logic  descend;
        logic  pop;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        t_req req_kind;
        logic req_empty;
        logic req_oob;
        logic clr_last;
        logic walk_query;
        logic disjoint;
        logic covered;
        logic leaf;
        logic stack_empty;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// File: hdl/rcst_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rcst_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/rcst_datapath.sv
// Datapath of the clamp tree: node memory, walk registers, stack and result register.
`default_nettype none
module rcst_datapath #(
    parameter int NUM_POSITIONS = 1024,
    parameter int HEIGHT_BITS   = 17
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rcst_pkg::t_cmd              i_cmd,
    output rcst_pkg::t_status                o_status,
    input  wire logic [rcst_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [rcst_pkg::POS_W-1:0]  i_range_left,
    input  wire logic [rcst_pkg::POS_W-1:0]  i_range_right,
    input  wire logic [rcst_pkg::HIN_W-1:0]  i_height,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [rcst_pkg::HOUT_W-1:0] o_height_out
);
    import rcst_pkg::*;

    localparam int IDXW  = $clog2(NUM_POSITIONS);
    localparam int AW    = IDXW + 2;
    localparam int DEPTH = 4 * NUM_POSITIONS;
    localparam int LW    = (IDXW > POS_W) ? IDXW : POS_W;
    localparam int SD    = IDXW + 1;
    localparam int SPW   = $clog2(SD + 1);
    localparam int SIW   = $clog2(SD);
    localparam int NW    = 2 * HEIGHT_BITS;
    localparam logic [LW-1:0]   LAST_L = LW'(NUM_POSITIONS - 1);
    localparam logic [IDXW-1:0] LAST_I = IDXW'(NUM_POSITIONS - 1);
    localparam logic [AW-1:0]   CLR_LAST = AW'(DEPTH - 1);

    logic [AW-1:0]          r_u;
    logic [IDXW-1:0]        r_b;
    logic [IDXW-1:0]        r_e;
    logic [IDXW-1:0]        r_lo;
    logic [IDXW-1:0]        r_hi;
    logic [HEIGHT_BITS-1:0] r_v;
    logic                   r_lower;
    logic                   r_query;
    logic                   r_oob;
    logic [NW-1:0]          r_par;
    logic [AW-1:0]          r_stk_u [SD];
    logic [IDXW-1:0]        r_stk_b [SD];
    logic [IDXW-1:0]        r_stk_e [SD];
    logic [SPW-1:0]         r_sp;
    logic [AW-1:0]          r_clr;
    logic                   r_out_valid;
    logic [HOUT_W-1:0]      r_out_h;

    logic [LW-1:0]          left_l;
    logic [LW-1:0]          right_l;
    logic [LW-1:0]          right_s;
    logic [IDXW-1:0]        mid;
    logic [IDXW-1:0]        mid_p1;
    logic [AW-1:0]          left_c;
    logic [AW-1:0]          right_c;
    logic [SIW-1:0]         top;
    logic [NW-1:0]          rdata;
    logic [NW-1:0]          wdata;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic                   we;
    logic [HEIGHT_BITS-1:0] rd_cap;
    logic [HEIGHT_BITS-1:0] rd_flr;
    logic [HEIGHT_BITS-1:0] par_cap;
    logic [HEIGHT_BITS-1:0] par_flr;
    logic [HEIGHT_BITS-1:0] ap_cap;
    logic [HEIGHT_BITS-1:0] ap_flr;
    logic [HEIGHT_BITS-1:0] cv_cap;
    logic [HEIGHT_BITS-1:0] cv_flr;
    logic [HEIGHT_BITS-1:0] t_cap;
    logic [HEIGHT_BITS-1:0] t_flr;

    assign left_l  = LW'(i_range_left);
    assign right_l = LW'(i_range_right);
    assign right_s = (right_l > LAST_L) ? LAST_L : right_l;
    assign mid     = r_b + ((r_e - r_b) >> 1);
    assign mid_p1  = mid + 1'b1;
    assign left_c  = {r_u[AW-2:0], 1'b0};
    assign right_c = {r_u[AW-2:0], 1'b1};
    assign top     = SIW'(r_sp - 1'b1);

    assign rd_cap  = rdata[NW-1:HEIGHT_BITS];
    assign rd_flr  = rdata[HEIGHT_BITS-1:0];
    assign par_cap = r_par[NW-1:HEIGHT_BITS];
    assign par_flr = r_par[HEIGHT_BITS-1:0];

    always_comb begin
        t_cap  = (rd_cap < par_cap) ? rd_cap : par_cap;
        t_flr  = (rd_flr < par_cap) ? rd_flr : par_cap;
        ap_cap = (t_cap > par_flr) ? t_cap : par_flr;
        ap_flr = (t_flr > par_flr) ? t_flr : par_flr;
        if (r_lower) begin
            cv_cap = (rd_cap < r_v) ? rd_cap : r_v;
            cv_flr = (rd_flr < r_v) ? rd_flr : r_v;
        end else begin
            cv_cap = (rd_cap > r_v) ? rd_cap : r_v;
            cv_flr = (rd_flr > r_v) ? rd_flr : r_v;
        end
    end

    always_comb begin
        unique case (i_cmd.rsel)
            RS_U:    raddr = r_u;
            RS_L:    raddr = left_c;
            RS_R:    raddr = right_c;
            default: raddr = r_u;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = r_u;
        wdata = rdata;
        unique case (i_cmd.wsel)
            WS_NONE: begin
                we = 1'b0;
            end
            WS_CLEAR: begin
                waddr = r_clr;
                wdata = '0;
            end
            WS_COVER: begin
                wdata = {cv_cap, cv_flr};
            end
            WS_LEFT: begin
                waddr = left_c;
                wdata = {ap_cap, ap_flr};
            end
            WS_RIGHT: begin
                waddr = right_c;
                wdata = {ap_cap, ap_flr};
            end
            WS_IDENT: begin
                wdata = {{HEIGHT_BITS{1'b1}}, {HEIGHT_BITS{1'b0}}};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    rcst_ram #(
        .WIDTH(NW),
        .DEPTH(DEPTH)
    ) u_nodes (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wsel == WS_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.start) begin
                r_sp <= '0;
            end else if (i_cmd.descend && !r_query) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_u     <= AW'(1);
            r_b     <= '0;
            r_e     <= LAST_I;
            r_lo    <= left_l[IDXW-1:0];
            r_hi    <= right_s[IDXW-1:0];
            r_v     <= HEIGHT_BITS'(i_height);
            r_lower <= (t_req'(i_req_type) == REQ_LOWER);
            r_query <= (t_req'(i_req_type) == REQ_QUERY);
            r_oob   <= (left_l > LAST_L);
        end else if (i_cmd.descend) begin
            if (r_query) begin
                if (r_lo <= mid) begin
                    r_u <= left_c;
                    r_e <= mid;
                end else begin
                    r_u <= right_c;
                    r_b <= mid_p1;
                end
            end else begin
                r_stk_u[SIW'(r_sp)] <= right_c;
                r_stk_b[SIW'(r_sp)] <= mid_p1;
                r_stk_e[SIW'(r_sp)] <= r_e;
                r_u <= left_c;
                r_e <= mid;
            end
        end else if (i_cmd.pop) begin
            r_u <= r_stk_u[top];
            r_b <= r_stk_b[top];
            r_e <= r_stk_e[top];
        end
        if (i_cmd.latch_par) begin
            r_par <= rdata;
        end
        if (i_cmd.out_load) begin
            r_out_h <= r_oob ? '0 : HOUT_W'(par_cap);
        end
    end

    always_comb begin
        o_status.req_kind    = t_req'(i_req_type);
        o_status.req_empty   = (left_l > right_s);
        o_status.req_oob     = (left_l > LAST_L);
        o_status.clr_last    = (r_clr == CLR_LAST);
        o_status.walk_query  = r_query;
        o_status.disjoint    = (r_b > r_hi) || (r_e < r_lo);
        o_status.covered     = (r_b >= r_lo) && (r_e <= r_hi);
        o_status.leaf        = (r_b == r_e);
        o_status.stack_empty = (r_sp == '0);
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid  = r_out_valid;
    assign o_height_out = r_out_h;
endmodule
`default_nettype wire

// File: hdl/rcst_ctrl.sv
// Controller state machine that sequences the tree walk and the input transfer.
`default_nettype none
module rcst_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rcst_pkg::t_status i_status,
    output rcst_pkg::t_cmd         o_cmd
);
    import rcst_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_update;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign is_update = (i_status.req_kind == REQ_RAISE) || (i_status.req_kind == REQ_LOWER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_status.req_kind == REQ_QUERY) begin
                        n_state = i_status.req_oob ? S_OUT : S_FETCH;
                    end else if (is_update && !i_status.req_empty) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_EVAL;
            S_EVAL: begin
                priority if (i_status.walk_query) begin
                    n_state = i_status.leaf ? S_OUT : S_CHL;
                end else if (i_status.disjoint || i_status.covered) begin
                    n_state = i_status.stack_empty ? S_IDLE : S_FETCH;
                end else begin
                    n_state = S_CHL;
                end
            end
            S_CHL: n_state = S_CHR;
            S_CHR: n_state = S_PAR;
            S_PAR: n_state = S_FETCH;
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.rsel      = RS_U;
        o_cmd.wsel      = WS_NONE;
        o_in_stall      = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wsel = WS_CLEAR;
            end
            S_IDLE: begin
                o_cmd.start = accept;
            end
            S_FETCH: begin
                o_cmd.rsel = RS_U;
            end
            S_EVAL: begin
                o_cmd.latch_par = 1'b1;
                o_cmd.rsel      = RS_L;
                if (!i_status.walk_query && !i_status.disjoint) begin
                    if (i_status.covered) begin
                        o_cmd.wsel = WS_COVER;
                    end
                end
                if (!i_status.walk_query && (i_status.disjoint || i_status.covered)
                        && !i_status.stack_empty) begin
                    o_cmd.pop = 1'b1;
                end
            end
            S_CHL: begin
                o_cmd.wsel = WS_LEFT;
                o_cmd.rsel = RS_R;
            end
            S_CHR: begin
                o_cmd.wsel = WS_RIGHT;
            end
            S_PAR: begin
                o_cmd.wsel    = WS_IDENT;
                o_cmd.descend = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd.wsel = WS_NONE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/range_clamp_segment_tree.sv
// Walk: an update passes FETCH and EVAL at each fully covered or disjoint node and adds CHL, CHR
// and PAR at each split node, about 4 * log2(NUM_POSITIONS) node visits; a query passes all five
// per level above the leaf, then OUT. One request at a time; the node memory bounds each step.
// After reset all 4 * NUM_POSITIONS node memory entries are cleared with input stalled.
// Reset is synchronous and active low; it empties the result register.
`default_nettype none
module range_clamp_segment_tree #(
    parameter int NUM_POSITIONS = 1024,
    parameter int HEIGHT_BITS   = 17
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [rcst_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [rcst_pkg::POS_W-1:0]  i_range_left,
    input  wire logic [rcst_pkg::POS_W-1:0]  i_range_right,
    input  wire logic [rcst_pkg::HIN_W-1:0]  i_height,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [rcst_pkg::HOUT_W-1:0] o_height_out
);
    import rcst_pkg::*;

    t_cmd    cmd;
    t_status status;

    rcst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    rcst_datapath #(
        .NUM_POSITIONS(NUM_POSITIONS),
        .HEIGHT_BITS  (HEIGHT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_req_type   (i_req_type),
        .i_range_left (i_range_left),
        .i_range_right(i_range_right),
        .i_height     (i_height),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_height_out (o_height_out)
    );
endmodule
`default_nettype wire
